[rtl/upri_pkg.sv]
`timescale 1ns / 1ps

package upri_pkg;

    localparam int TIME_W = 48;
    localparam int POS_W  = 32;
    localparam int STEP_W = 32;
    localparam int MAG_W  = POS_W + 1;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd6554;
    localparam int REG_GRID_STEP = 0;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_LATER   = 2'd1,
        ST_OUT_OF_SPAN = 2'd2,
        ST_FULL        = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] t;
        t_pos              pos;
    } t_item;

    typedef struct packed {
        t_status status;
        t_pos    pos;
    } t_result;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_ADD_CHK,
        B_ADD_DIV,
        B_FILL,
        B_FILL_WAIT,
        B_COMMIT,
        B_Q_DIV,
        B_Q_MUL,
        B_Q_LEFT,
        B_Q_RIGHT,
        B_Q_PICK,
        B_Q_LERP,
        B_RESULT
    } t_bstate;

endpackage

[rtl/upri_if.sv]
`timescale 1ns / 1ps

interface upri_in_if;
    import upri_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [TIME_W-1:0]       sample_time;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    modport source (output valid, operation, sample_time, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, operation, sample_time, pos_x, pos_y, pos_z, output ready);
endinterface

interface upri_out_if;
    import upri_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    modport source (output valid, status, out_x, out_y, out_z, input ready);
    modport sink (input valid, status, out_x, out_y, out_z, output ready);
endinterface

[rtl/uniform_path_resample_interpolate.sv]
`timescale 1ns / 1ps

// Uniform-grid trajectory resampler.
// Input words arrive on i_in (valid/ready): an add carries a Q32.16 time and a
// Q16.16 position, a query carries a time. Every word gives exactly one result
// word on o_out (valid/ready): a status and, for a good query, the position.
// The grid step is set through the APB port at address 0; the user must write it
// only while the block idles, as the block does not enforce it. A two-word queue
// takes input words while the back end works, so input and output stall
// independently; a finished result sits in the output register until it is taken,
// and the back end waits before loading the next one. A first add or an
// out-of-span query goes straight to the result, and a not-later add is turned
// away after one check. A later add runs the step divider (a store-full
// rejection likewise), then copies or interpolates each grid point in turn with
// the multiply-divide units; a query runs the divider, grid store reads and one
// interpolation. One word is worked on at a time.
// Reset empties the queue and the output register, forgets the origin and
// grid, and sets the step to 6554 (about 0.1 s). The grid store needs no
// clearing, as only written entries are ever read.
module uniform_path_resample_interpolate #(
    parameter int GRID_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    upri_in_if.sink                      i_in,
    upri_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [upri_pkg::ADDR_W-1:0]  paddr,
    input  logic [upri_pkg::DATA_W-1:0]  pwdata,
    output logic [upri_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import upri_pkg::*;

    logic              r_step;
    logic [STEP_W-1:0] r_grid_step;
    logic              w_hit;
    logic              w_q_valid;
    t_item             w_q_item;
    logic              w_q_ready;
    logic              w_out_valid;
    t_result           w_result;

    assign pready = 1'b1;
    assign w_hit  = (paddr[ADDR_W-1:2] == 1'(REG_GRID_STEP));
    assign prdata = w_hit ? DATA_W'(r_grid_step) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step <= STEP_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_grid_step <= pwdata[STEP_W-1:0];
        end
    end

    // Marks a cycle with a result waiting on a stalled receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
        end else begin
            r_step <= w_out_valid & ~o_out.ready;
        end
    end

    upri_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_ready (w_q_ready)
    );

    upri_back #(
        .GRID_DEPTH (GRID_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_ready     (w_q_ready),
        .i_step      (r_grid_step),
        .o_valid     (w_out_valid),
        .o_result    (w_result),
        .i_out_ready (o_out.ready)
    );

    assign o_out.valid  = w_out_valid;
    assign o_out.status = w_result.status;
    assign o_out.out_x  = w_result.pos.x;
    assign o_out.out_y  = w_result.pos.y;
    assign o_out.out_z  = w_result.pos.z;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step |-> (w_out_valid && $stable(w_result)))
        else $error("stalled result word changed");

    a_ready_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

    a_step_resets: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_grid_step == STEP_RESET))
        else $error("grid step not restored by reset");

endmodule

[rtl/upri_front.sv]
`timescale 1ns / 1ps

module upri_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    upri_in_if.sink        i_in,
    output logic           o_valid,
    output upri_pkg::t_item o_item,
    input  logic           i_ready
);
    import upri_pkg::*;

    logic [1:0] r_count;
    logic       r_wptr;
    logic       r_rptr;
    t_item      r_slot [2];
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.op    = t_op'(i_in.operation);
        w_item.t     = i_in.sample_time;
        w_item.pos.x = i_in.pos_x;
        w_item.pos.y = i_in.pos_y;
        w_item.pos.z = i_in.pos_z;
    end

    assign i_in.ready = (r_count != 2'd2);
    assign w_push     = i_in.valid & i_in.ready;
    assign o_valid    = (r_count != 2'd0);
    assign w_pop      = o_valid & i_ready;
    assign o_item     = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= w_item;
        end
    end

endmodule

[rtl/upri_div.sv]
`timescale 1ns / 1ps

module upri_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [upri_pkg::TIME_W-1:0]   i_dividend,
    input  logic [upri_pkg::STEP_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [upri_pkg::TIME_W-1:0]   o_quot
);
    import upri_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_dvs;
    logic [TIME_W-1:0] r_quot;
    logic [STEP_W:0]   w_trial;
    logic [STEP_W:0]   w_diff;
    logic              w_bit;

    // One quotient bit a cycle: the dividend shifts out as the quotient shifts in.
    assign w_trial = {r_rem, r_quot[TIME_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_bit   = (w_trial >= {1'b0, r_dvs});
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CNT_W'(TIME_W - 1);
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rem  <= w_bit ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
            r_quot <= {r_quot[TIME_W-2:0], w_bit};
        end
    end

endmodule

[rtl/upri_lerp.sv]
`timescale 1ns / 1ps

module upri_lerp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [upri_pkg::POS_W-1:0]  i_p0,
    input  logic signed [upri_pkg::POS_W-1:0]  i_p1,
    input  logic [upri_pkg::TIME_W-1:0]        i_num,
    input  logic [upri_pkg::TIME_W-1:0]        i_den,
    output logic                               o_done,
    output logic signed [upri_pkg::POS_W-1:0]  o_val
);
    import upri_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);
    localparam int ACC_W = TIME_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [POS_W-1:0]  r_p0;
    logic [TIME_W-1:0] r_num;
    logic [TIME_W-1:0] r_den;
    logic [TIME_W-1:0] r_rem;
    logic [MAG_W-1:0]  r_q;

    logic [MAG_W-1:0]  w_diff;
    logic [MAG_W-1:0]  w_mag;
    logic [ACC_W-1:0]  w_acc;
    logic [ACC_W-1:0]  w_den1;
    logic [ACC_W-1:0]  w_den2;
    logic [ACC_W-1:0]  w_acc_n;
    logic [1:0]        w_digit;
    logic [MAG_W:0]    w_sum;

    assign w_diff = {i_p1[POS_W-1], i_p1} - {i_p0[POS_W-1], i_p0};
    assign w_mag  = w_diff[MAG_W-1] ? (~w_diff + 1'b1) : w_diff;

    // Interleaved multiply and divide: the remainder stays below the
    // denominator, so each step yields a quotient digit of 0, 1 or 2.
    assign w_acc  = {1'b0, r_rem, 1'b0} + (r_mag[MAG_W-1] ? {2'b00, r_num} : '0);
    assign w_den1 = {2'b00, r_den};
    assign w_den2 = {1'b0, r_den, 1'b0};

    always_comb begin
        if (w_acc >= w_den2) begin
            w_acc_n = w_acc - w_den2;
            w_digit = 2'd2;
        end else if (w_acc >= w_den1) begin
            w_acc_n = w_acc - w_den1;
            w_digit = 2'd1;
        end else begin
            w_acc_n = w_acc;
            w_digit = 2'd0;
        end
    end

    assign w_sum  = r_neg ? ({r_p0[POS_W-1], r_p0[POS_W-1], r_p0} - {1'b0, r_q})
                          : ({r_p0[POS_W-1], r_p0[POS_W-1], r_p0} + {1'b0, r_q});
    assign o_val  = w_sum[POS_W-1:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(MAG_W - 1);
            r_mag <= w_mag;
            r_neg <= w_diff[MAG_W-1];
            r_p0  <= i_p0;
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem <= w_acc_n[TIME_W-1:0];
            r_q   <= {r_q[MAG_W-2:0], 1'b0} + MAG_W'(w_digit);
        end
    end

endmodule

[rtl/upri_back.sv]
`timescale 1ns / 1ps

module upri_back #(
    parameter int GRID_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  upri_pkg::t_item              i_item,
    output logic                         o_ready,
    input  logic [upri_pkg::STEP_W-1:0]  i_step,
    output logic                         o_valid,
    output upri_pkg::t_result            o_result,
    input  logic                         i_out_ready
);
    import upri_pkg::*;

    localparam int AW   = $clog2(GRID_DEPTH);
    localparam int CW   = $clog2(GRID_DEPTH + 1);
    localparam int PW   = CW + STEP_W;
    localparam int GT_W = ((PW > TIME_W) ? PW : TIME_W) + 2;
    localparam logic [TIME_W:0] DEPTH_X = (TIME_W + 1)'(GRID_DEPTH);

    t_bstate           r_state, n_state;
    t_item             r_item, n_item;
    logic              r_has_origin, n_has_origin;
    logic              r_has_end, n_has_end;
    logic [TIME_W-1:0] r_origin, n_origin;
    logic [TIME_W-1:0] r_end, n_end;
    logic [CW-1:0]     r_gc, n_gc;
    logic [TIME_W-1:0] r_last_t, n_last_t;
    t_pos              r_last, n_last;
    logic [GT_W-1:0]   r_gpt, n_gpt;
    logic [CW-1:0]     r_wr_idx, n_wr_idx;
    logic [CW-1:0]     r_remain, n_remain;
    logic [AW-1:0]     r_idx, n_idx;
    logic [GT_W-1:0]   r_left_t, n_left_t;
    logic [GT_W-1:0]   r_right_t, n_right_t;
    t_pos              r_left, n_left;
    t_pos              r_right, n_right;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic [PW-1:0]     r_prod;

    t_pos              r_mem [GRID_DEPTH];
    t_pos              r_rd;

    logic [STEP_W-1:0] w_step;
    logic [CW-1:0]     w_gcm1;
    logic [CW-1:0]     w_mul_a;
    logic [PW-1:0]     w_mul;
    logic [GT_W-1:0]   w_t;
    logic [GT_W-1:0]   w_lg;
    logic [GT_W-1:0]   w_g;
    logic [GT_W-1:0]   w_qnum;
    logic [GT_W-1:0]   w_qden;
    logic [TIME_W:0]   w_need;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_pos              w_wdata;
    logic [AW-1:0]     w_raddr;

    logic              w_div_start;
    logic [TIME_W-1:0] w_div_dvd;
    logic              w_div_done;
    logic [TIME_W-1:0] w_quot;

    logic              w_lerp_start;
    t_pos              w_lp0;
    t_pos              w_lp1;
    logic [TIME_W-1:0] w_lnum;
    logic [TIME_W-1:0] w_lden;
    logic              w_done_x, w_done_y, w_done_z;
    t_pos              w_lerp;

    assign w_step  = (i_step == '0) ? STEP_W'(1) : i_step;
    assign w_gcm1  = r_gc - 1'b1;
    assign w_mul_a = (r_state == B_START) ? w_gcm1 : CW'(r_idx);
    assign w_mul   = w_mul_a * w_step;
    assign w_t     = GT_W'(r_item.t);
    assign w_lg    = GT_W'(r_origin) + GT_W'(r_prod);
    assign w_g     = r_gpt + GT_W'(w_step);
    assign w_qnum  = w_t - r_left_t;
    assign w_qden  = r_right_t - r_left_t;
    assign w_need  = (TIME_W + 1)'(r_gc) + {1'b0, w_quot};

    assign o_ready  = (r_state == B_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    upri_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_step),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    upri_lerp u_lerp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_p0    (w_lp0.x),
        .i_p1    (w_lp1.x),
        .i_num   (w_lnum),
        .i_den   (w_lden),
        .o_done  (w_done_x),
        .o_val   (w_lerp.x)
    );

    upri_lerp u_lerp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_p0    (w_lp0.y),
        .i_p1    (w_lp1.y),
        .i_num   (w_lnum),
        .i_den   (w_lden),
        .o_done  (w_done_y),
        .o_val   (w_lerp.y)
    );

    upri_lerp u_lerp_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_p0    (w_lp0.z),
        .i_p1    (w_lp1.z),
        .i_num   (w_lnum),
        .i_den   (w_lden),
        .o_done  (w_done_z),
        .o_val   (w_lerp.z)
    );

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_has_origin = r_has_origin;
        n_has_end    = r_has_end;
        n_origin     = r_origin;
        n_end        = r_end;
        n_gc         = r_gc;
        n_last_t     = r_last_t;
        n_last       = r_last;
        n_gpt        = r_gpt;
        n_wr_idx     = r_wr_idx;
        n_remain     = r_remain;
        n_idx        = r_idx;
        n_left_t     = r_left_t;
        n_right_t    = r_right_t;
        n_left       = r_left;
        n_right      = r_right;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid & ~i_out_ready;

        w_we         = 1'b0;
        w_waddr      = r_wr_idx[AW-1:0];
        w_wdata      = r_item.pos;
        w_raddr      = r_idx;
        w_div_start  = 1'b0;
        w_div_dvd    = r_item.t - r_origin;
        w_lerp_start = 1'b0;
        w_lp0        = r_last;
        w_lp1        = r_item.pos;
        w_lnum       = w_g[TIME_W-1:0] - r_last_t;
        w_lden       = r_item.t - r_last_t;

        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    n_item  = i_item;
                    n_state = B_START;
                end
            end
            B_START: begin
                if (r_item.op == OP_ADD) begin
                    if (!r_has_origin) begin
                        // The first add word only fixes the origin and grid point zero.
                        n_has_origin = 1'b1;
                        n_origin     = r_item.t;
                        n_last_t     = r_item.t;
                        n_last       = r_item.pos;
                        n_gc         = CW'(1);
                        w_we         = 1'b1;
                        w_waddr      = '0;
                        n_res        = '{status: ST_OK, pos: '0};
                        n_state      = B_RESULT;
                    end else begin
                        n_state = B_ADD_CHK;
                    end
                end else begin
                    if (!r_has_end || r_gc == '0 || r_item.t < r_origin
                            || r_item.t > r_end) begin
                        n_res   = '{status: ST_OUT_OF_SPAN, pos: '0};
                        n_state = B_RESULT;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = B_Q_DIV;
                    end
                end
            end
            B_ADD_CHK: begin
                if (r_item.t <= r_origin || w_t <= w_lg) begin
                    n_res   = '{status: ST_NOT_LATER, pos: '0};
                    n_state = B_RESULT;
                end else begin
                    w_div_start = 1'b1;
                    w_div_dvd   = w_t[TIME_W-1:0] - w_lg[TIME_W-1:0];
                    n_gpt       = w_lg;
                    n_state     = B_ADD_DIV;
                end
            end
            B_ADD_DIV: begin
                if (w_div_done) begin
                    n_wr_idx = r_gc;
                    if (w_need > DEPTH_X) begin
                        n_res   = '{status: ST_FULL, pos: '0};
                        n_state = B_RESULT;
                    end else if (w_quot == '0) begin
                        n_state = B_COMMIT;
                    end else begin
                        n_remain = w_quot[CW-1:0];
                        n_state  = B_FILL;
                    end
                end
            end
            B_FILL: begin
                n_gpt = w_g;
                if (w_g >= w_t || w_g <= GT_W'(r_last_t)) begin
                    w_we     = 1'b1;
                    w_wdata  = (w_g >= w_t) ? r_item.pos : r_last;
                    n_wr_idx = r_wr_idx + 1'b1;
                    n_remain = r_remain - 1'b1;
                    n_state  = (r_remain == CW'(1)) ? B_COMMIT : B_FILL;
                end else begin
                    w_lerp_start = 1'b1;
                    n_state      = B_FILL_WAIT;
                end
            end
            B_FILL_WAIT: begin
                if (w_done_x && w_done_y && w_done_z) begin
                    w_we     = 1'b1;
                    w_wdata  = w_lerp;
                    n_wr_idx = r_wr_idx + 1'b1;
                    n_remain = r_remain - 1'b1;
                    n_state  = (r_remain == CW'(1)) ? B_COMMIT : B_FILL;
                end
            end
            B_COMMIT: begin
                n_gc      = r_wr_idx;
                n_last_t  = r_item.t;
                n_last    = r_item.pos;
                n_end     = r_item.t;
                n_has_end = 1'b1;
                n_res     = '{status: ST_OK, pos: '0};
                n_state   = B_RESULT;
            end
            B_Q_DIV: begin
                if (w_div_done) begin
                    if (w_quot > TIME_W'(w_gcm1)) begin
                        n_idx = w_gcm1[AW-1:0];
                    end else begin
                        n_idx = w_quot[AW-1:0];
                    end
                    n_state = B_Q_MUL;
                end
            end
            B_Q_MUL: begin
                n_state = B_Q_LEFT;
            end
            B_Q_LEFT: begin
                n_left   = r_rd;
                n_left_t = w_lg;
                w_raddr  = r_idx + 1'b1;
                n_state  = B_Q_RIGHT;
            end
            B_Q_RIGHT: begin
                if (CW'(r_idx) + 1'b1 < r_gc) begin
                    n_right   = r_rd;
                    n_right_t = r_left_t + GT_W'(w_step);
                end else begin
                    n_right   = r_last;
                    n_right_t = GT_W'(r_last_t);
                end
                n_state = B_Q_PICK;
            end
            B_Q_PICK: begin
                w_lp0  = r_left;
                w_lp1  = r_right;
                w_lden = w_qden[TIME_W-1:0];
                w_lnum = (w_qnum > w_qden) ? w_qden[TIME_W-1:0] : w_qnum[TIME_W-1:0];
                if (r_right_t <= r_left_t || w_t <= r_left_t) begin
                    n_res   = '{status: ST_OK, pos: r_left};
                    n_state = B_RESULT;
                end else begin
                    w_lerp_start = 1'b1;
                    n_state      = B_Q_LERP;
                end
            end
            B_Q_LERP: begin
                if (w_done_x && w_done_y && w_done_z) begin
                    n_res   = '{status: ST_OK, pos: w_lerp};
                    n_state = B_RESULT;
                end
            end
            B_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_has_origin <= 1'b0;
            r_has_end    <= 1'b0;
            r_gc         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_has_origin <= n_has_origin;
            r_has_end    <= n_has_end;
            r_gc         <= n_gc;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_origin  <= n_origin;
        r_end     <= n_end;
        r_last_t  <= n_last_t;
        r_last    <= n_last;
        r_gpt     <= n_gpt;
        r_wr_idx  <= n_wr_idx;
        r_remain  <= n_remain;
        r_idx     <= n_idx;
        r_left_t  <= n_left_t;
        r_right_t <= n_right_t;
        r_left    <= n_left;
        r_right   <= n_right;
        r_res     <= n_res;
        r_out     <= n_out;
        r_prod    <= w_mul;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    a_gc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= CW'(GRID_DEPTH))
        else $error("grid count beyond store depth");

    a_end_needs_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_end |-> r_has_origin)
        else $error("span end set without an origin");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL || r_state == B_FILL_WAIT) |->
            (r_wr_idx < CW'(GRID_DEPTH) && r_remain != '0))
        else $error("grid fill runs past the store");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == B_RESULT))
        else $error("result word raised outside the result state");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import upri_pkg::*;

    localparam int DEPTH       = 4096;
    localparam int QUIET_LIMIT = 1000000;
    localparam logic [63:0] T_MASK = 64'hFFFF_FFFF_FFFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    upri_in_if  in_if ();
    upri_out_if out_if ();

    uniform_path_resample_interpolate #(.GRID_DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the resampler state.
    logic [31:0]             step_reg;
    bit                      have_org, have_end;
    logic [63:0]             org_t, end_t, last_t;
    int                      n_grid;
    t_pos                    last_p;
    logic signed [POS_W-1:0] gx [DEPTH];
    logic signed [POS_W-1:0] gy [DEPTH];
    logic signed [POS_W-1:0] gz [DEPTH];

    t_item   pending_words [$];
    t_result expected_results [$];
    int      err_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      quiet_cycles = 0;

    function automatic logic [63:0] eff_step();
        return (step_reg == 0) ? 64'd1 : 64'(step_reg);
    endfunction

    function automatic logic [63:0] last_grid_time();
        return org_t + 64'(n_grid - 1) * eff_step();
    endfunction

    // Exact p0 + (p1-p0)*num/den, truncated toward zero.
    function automatic logic signed [31:0] lerp32(logic signed [31:0] a, logic signed [31:0] b,
                                                  logic [63:0] num, logic [63:0] den);
        longint       d;
        logic [63:0]  mag;
        logic [127:0] q;
        d = longint'(b) - longint'(a);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q = (128'(mag) * 128'(num)) / 128'(den);
        return (d < 0) ? a - q[31:0] : a + q[31:0];
    endfunction

    function automatic t_pos lerp_pos(t_pos a, t_pos b, logic [63:0] num, logic [63:0] den);
        t_pos r;
        r.x = lerp32(a.x, b.x, num, den);
        r.y = lerp32(a.y, b.y, num, den);
        r.z = lerp32(a.z, b.z, num, den);
        return r;
    endfunction

    function automatic t_status resample_add(logic [63:0] t, t_pos p);
        logic [63:0] lg, need, g, stp;
        t_pos        v;
        int          idx;
        stp = eff_step();
        if (!have_org) begin
            have_org = 1;
            org_t = t;
            last_t = t;
            last_p = p;
            gx[0] = p.x; gy[0] = p.y; gz[0] = p.z;
            n_grid = 1;
            return ST_OK;
        end
        lg = last_grid_time();
        if (t <= org_t || t <= lg) return ST_NOT_LATER;
        need = (t - lg) / stp;
        if (64'(n_grid) + need > 64'(DEPTH)) return ST_FULL;
        for (longint k = 1; k <= longint'(need); k++) begin
            g = lg + 64'(k) * stp;
            idx = n_grid + int'(k) - 1;
            if (g >= t) v = p;
            else if (g <= last_t) v = last_p;
            else v = lerp_pos(last_p, p, g - last_t, t - last_t);
            gx[idx] = v.x; gy[idx] = v.y; gz[idx] = v.z;
        end
        n_grid += int'(need);
        last_t = t;
        last_p = p;
        end_t = t;
        have_end = 1;
        return ST_OK;
    endfunction

    function automatic t_result resample_query(logic [63:0] t);
        t_result     r;
        logic [63:0] idx, left_t, right_t, num, den, stp;
        t_pos        lp, rp;
        r = '0;
        r.status = ST_OUT_OF_SPAN;
        stp = eff_step();
        if (!have_end || n_grid == 0 || t < org_t || t > end_t) return r;
        idx = (t - org_t) / stp;
        if (idx > 64'(n_grid - 1)) idx = 64'(n_grid - 1);
        left_t = org_t + idx * stp;
        lp.x = gx[idx]; lp.y = gy[idx]; lp.z = gz[idx];
        if (idx + 1 < 64'(n_grid)) begin
            right_t = left_t + stp;
            rp.x = gx[idx+1]; rp.y = gy[idx+1]; rp.z = gz[idx+1];
        end else begin
            right_t = last_t;
            rp = last_p;
        end
        r.status = ST_OK;
        if (right_t <= left_t || t <= left_t) begin
            r.pos = lp;
        end else begin
            num = t - left_t;
            den = right_t - left_t;
            if (num > den) num = den;
            r.pos = lerp_pos(lp, rp, num, den);
        end
        return r;
    endfunction

    task automatic queue_word(t_op op, logic [63:0] t, t_pos p);
        t_item   w;
        t_result r;
        w.op = op;
        w.t = t[TIME_W-1:0];
        w.pos = p;
        if (op == OP_ADD) begin
            r = '0;
            r.status = resample_add(64'(w.t), p);
        end else begin
            r = resample_query(64'(w.t));
        end
        pending_words = {pending_words, w};
        expected_results = {expected_results, r};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pos rand_pos();
        t_pos p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] add_time();
        logic [63:0] lg, stp;
        int          r;
        if (!have_org) return {20'h0, 12'($urandom), 32'($urandom)} | 64'd1;
        stp = eff_step();
        lg = last_grid_time();
        r = $urandom_range(0, 99);
        if (r < 70)
            return (lg + stp * $urandom_range(0, 4) + $urandom_range(1, 32'(stp))) & T_MASK;
        if (r < 80)
            return (last_t > lg) ? lg + 1 + rand64() % (last_t - lg) : (lg + 1) & T_MASK;
        if (r < 90) return (rand64() % (lg + 1)) & T_MASK;
        if (r < 95) return (lg + stp * 5000) & T_MASK;
        return rand64() & T_MASK;
    endfunction

    function automatic logic [63:0] query_time();
        int r;
        r = $urandom_range(0, 99);
        if (!have_end || r >= 90) return rand64() & T_MASK;
        if (r < 60) return org_t + rand64() % (end_t - org_t + 1);
        if (r < 70) return (org_t + eff_step() * $urandom_range(0, n_grid)) & T_MASK;
        if (r < 75) return end_t;
        if (r < 80) return org_t;
        if (r < 85) return (end_t + 1) & T_MASK;
        return (org_t - 1) & T_MASK;
    endfunction

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        step_reg = data;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // Word driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_if.valid       <= 1'b1;
                in_if.operation   <= pending_words[0].op;
                in_if.sample_time <= pending_words[0].t;
                in_if.pos_x       <= pending_words[0].pos.x;
                in_if.pos_y       <= pending_words[0].pos.y;
                in_if.pos_z       <= pending_words[0].pos.z;
                void'(pending_words.pop_front());
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                report("result word with nothing outstanding", 32'(out_if.status), 32'h0);
            end else begin
                w = expected_results.pop_front();
                if (out_if.status != w.status) report("status", out_if.status, w.status);
                if (out_if.out_x != w.pos.x) report("out_x", out_if.out_x, w.pos.x);
                if (out_if.out_y != w.pos.y) report("out_y", out_if.out_y, w.pos.y);
                if (out_if.out_z != w.pos.z) report("out_z", out_if.out_z, w.pos.z);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] steps [6];
        logic [63:0] lg;
        t_pos        hi_p, lo_p;
        steps = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd6554, 32'd0};
        steps[5] = $urandom_range(100, 200000);
        in_if.valid = 1'b0; in_if.operation = 1'b0; in_if.sample_time = '0;
        in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
        out_if.ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        step_reg = STEP_RESET;
        have_org = 0; have_end = 0; org_t = 0; end_t = 0; last_t = 0; n_grid = 0;
        last_p = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        hi_p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        lo_p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        // Directed opening: queries before any span, origin, rejections, edges.
        queue_word(OP_QUERY, 64'd5, rand_pos());
        queue_word(OP_ADD, 64'd1000 << 16, lo_p);
        queue_word(OP_QUERY, 64'd1000 << 16, rand_pos());
        queue_word(OP_ADD, 64'd1000 << 16, hi_p);
        queue_word(OP_ADD, (64'd1000 << 16) + 3 * 6554 + 100, hi_p);
        queue_word(OP_QUERY, org_t, rand_pos());
        queue_word(OP_QUERY, end_t, rand_pos());
        queue_word(OP_QUERY, org_t + 6554 + 3000, rand_pos());
        queue_word(OP_QUERY, org_t + 2 * 6554, rand_pos());
        queue_word(OP_QUERY, end_t + 1, rand_pos());
        queue_word(OP_QUERY, org_t - 1, rand_pos());
        lg = last_grid_time();
        // Lands between the last grid time and the last sample.
        queue_word(OP_ADD, lg + 1, lo_p);
        queue_word(OP_QUERY, end_t, rand_pos());
        queue_word(OP_ADD, lg + 64'd6554 * 5000, hi_p);
        queue_word(OP_ADD, lg + 2 * 6554 + 7, lo_p);
        queue_word(OP_QUERY, end_t - 1, rand_pos());
        queue_word(OP_QUERY, T_MASK, rand_pos());
        queue_word(OP_ADD, 64'd0, rand_pos());
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            apb_write(ADDR_W'(REG_GRID_STEP * 4), steps[ph]);
            send_idle_pct = (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 18 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 57 : (ph % 4 == 3) ? 18 : 0;
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 99) < 60) queue_word(OP_ADD, add_time(), rand_pos());
                else queue_word(OP_QUERY, query_time(), rand_pos());
                // Let the sender hold back until everything so far is back.
                if (n == 75) wait_drained();
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
